>>> rtl/bap_pkg.sv
package bap_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_TILE   = 64;

	localparam int PIX_W  = 8;
	localparam int BS_W   = 7;
	localparam int IW_W   = 12;
	localparam int IH_W   = 13;
	localparam int COL_W  = 11;
	localparam int ROW_W  = 12;
	localparam int OFF_W  = 6;
	localparam int SUM_W  = 20;
	localparam int CNT_W  = 13;
	localparam int STEP_W = 5;
	localparam int CFG_W  = 13;
	localparam int IDX_W  = 2;
	localparam int ENTRY_W = 3 * SUM_W;

	localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	typedef logic [2:0][SUM_W-1:0] sum3_t;
	typedef logic [2:0][PIX_W-1:0] pix3_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/bap_if.sv
interface bap_pix_if import bap_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_blue;
	logic [PIX_W-1:0] pixel_green;
	logic [PIX_W-1:0] pixel_red;
	modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
	modport sink (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface bap_res_if import bap_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] avg_blue;
	logic [PIX_W-1:0] avg_green;
	logic [PIX_W-1:0] avg_red;
	logic [COL_W-1:0] tile_column;
	logic [ROW_W-1:0] tile_row;
	logic [BS_W-1:0]  tile_width;
	logic [BS_W-1:0]  tile_height;
	logic             frame_done;
	modport source (output valid, avg_blue, avg_green, avg_red, tile_column, tile_row,
		tile_width, tile_height, frame_done, input ready);
	modport sink (input valid, avg_blue, avg_green, avg_red, tile_column, tile_row,
		tile_width, tile_height, frame_done, output ready);
endinterface

>>> rtl/bap_ram.sv
module bap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bap_div.sv
module bap_div import bap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sum3_t            sums,
	input  logic [CNT_W-1:0] count,
	output div_stat_t        stat,
	output pix3_t            avg
);

	logic              busy_q, round_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q;
	sum3_t             dvd_q;
	logic [2:0][CNT_W-1:0] rem_q;
	pix3_t             avg_q;
	logic [2:0][CNT_W-1:0] trial;
	logic [2:0]        ge;
	logic [2:0][CNT_W:0] twice;
	logic [2:0]        up;
	logic [2:0][SUM_W:0] qr;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c][CNT_W-2:0], dvd_q[c][SUM_W-1]};
			ge[c]    = trial[c] >= cnt_q;
			twice[c] = {rem_q[c], 1'b0};
			// Round half to even: a remainder of exactly half rounds up on an odd quotient.
			up[c] = (twice[c] > {1'b0, cnt_q}) ||
				((twice[c] == {1'b0, cnt_q}) && dvd_q[c][0]);
			qr[c] = {1'b0, dvd_q[c]} + {{SUM_W{1'b0}}, up[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q  <= 1'b0;
					round_q <= 1'b1;
				end
			end else if (round_q) begin
				round_q <= 1'b0;
				done_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= sums;
			rem_q <= '0;
			cnt_q <= count;
		end else if (busy_q) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= ge[c] ? trial[c] - cnt_q : trial[c];
				dvd_q[c] <= {dvd_q[c][SUM_W-2:0], ge[c]};
			end
		end else if (round_q) begin
			for (int c = 0; c < 3; c++) begin
				avg_q[c] <= (qr[c] > (SUM_W+1)'(255)) ? 8'd255 : qr[c][PIX_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q | round_q;
	assign stat.done = done_q;
	assign avg       = avg_q;

endmodule

>>> rtl/block_average_pixelation.sv
// For each pixel the tile column's sums are read from the column memory,
// then updated and written back; no new pixel is accepted until the write-back is done.
// A tile's last pixel starts a restoring divider of 20 steps for all three channels;
// the rounded result goes to the result register, and the block waits during division.
// The result register lets the next pixel in while a result is still unclaimed.
// Reset clears counters and loads block size 1 and a 640 by 480 image; the memory is not cleared.
module block_average_pixelation import bap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	bap_pix_if.sink          pixel_in,
	bap_res_if.source        result_out
);

	state_t state_q;
	logic [BS_W-1:0] bs_cfg_q;
	logic [IW_W-1:0] w_cfg_q;
	logic [IH_W-1:0] h_cfg_q;
	logic [BS_W-1:0] bs;
	logic [IW_W-1:0] w;
	logic [IH_W-1:0] h;

	logic [COL_W-1:0] x_q, col_q;
	logic [ROW_W-1:0] y_q, row_q;
	logic [OFF_W-1:0] offx_q, offy_q;

	logic [COL_W-1:0] start_x;
	logic [ROW_W-1:0] start_y;
	logic [IW_W-1:0]  rem_w;
	logic [IH_W-1:0]  rem_h;
	logic [BS_W-1:0]  tw, th, offx_inc, offy_inc;
	logic             tile_end, last_x, last_y, accept, cfg_hit;
	logic [2*BS_W-1:0] area;

	logic             first_row_s1, tile_end_s1, fdone_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [BS_W-1:0]  tw_s1, th_s1;
	logic [CNT_W-1:0] count_s1;
	pix3_t            px_s1;

	logic [ENTRY_W-1:0] rd_data;
	sum3_t            rd_sums, new_sums;
	logic             div_start;
	div_stat_t        div_stat;
	pix3_t            div_avg;

	logic             out_valid_q, load_out;
	pix3_t            avg_q;
	logic [COL_W-1:0] tcol_q;
	logic [ROW_W-1:0] trow_q;
	logic [BS_W-1:0]  tw_q, th_q;
	logic             fdone_q;

	always_comb begin
		if (bs_cfg_q == '0) bs = BS_W'(1);
		else if (bs_cfg_q > BS_W'(MAX_TILE)) bs = BS_W'(MAX_TILE);
		else bs = bs_cfg_q;
		if (w_cfg_q == '0) w = IW_W'(1);
		else if (w_cfg_q > IW_W'(MAX_WIDTH)) w = IW_W'(MAX_WIDTH);
		else w = w_cfg_q;
		if (h_cfg_q == '0) h = IH_W'(1);
		else if (h_cfg_q > IH_W'(MAX_HEIGHT)) h = IH_W'(MAX_HEIGHT);
		else h = h_cfg_q;
	end

	assign start_x  = x_q - COL_W'(offx_q);
	assign start_y  = y_q - ROW_W'(offy_q);
	assign rem_w    = w - {1'b0, start_x};
	assign rem_h    = h - {1'b0, start_y};
	assign tw       = (rem_w < IW_W'(bs)) ? rem_w[BS_W-1:0] : bs;
	assign th       = (rem_h < IH_W'(bs)) ? rem_h[BS_W-1:0] : bs;
	assign offx_inc = {1'b0, offx_q} + 1'b1;
	assign offy_inc = {1'b0, offy_q} + 1'b1;
	assign tile_end = (offx_inc == tw) && (offy_inc == th);
	assign last_x   = ({1'b0, x_q} + 1'b1) == w;
	assign last_y   = ({1'b0, y_q} + 1'b1) == h;
	assign area     = tw * th;

	assign pixel_in.ready = (state_q == ST_IDLE);
	assign accept  = pixel_in.valid && pixel_in.ready;
	assign cfg_hit = cfg_we && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_IMAGE_WIDTH ||
		cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_cfg_q <= BS_W'(1);
			w_cfg_q  <= IW_W'(640);
			h_cfg_q  <= IH_W'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_SIZE:   bs_cfg_q <= cfg_data[BS_W-1:0];
				REG_IMAGE_WIDTH:  w_cfg_q  <= cfg_data[IW_W-1:0];
				REG_IMAGE_HEIGHT: h_cfg_q  <= cfg_data[IH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; offx_q <= '0; offy_q <= '0; col_q <= '0; row_q <= '0;
		end else if (cfg_hit) begin
			x_q <= '0; y_q <= '0; offx_q <= '0; offy_q <= '0; col_q <= '0; row_q <= '0;
		end else if (accept) begin
			if (last_x) begin
				x_q <= '0; offx_q <= '0; col_q <= '0;
				if (last_y) begin
					y_q <= '0; offy_q <= '0; row_q <= '0;
				end else begin
					y_q <= y_q + 1'b1;
					if (offy_inc == bs) begin
						offy_q <= '0;
						row_q  <= row_q + 1'b1;
					end else begin
						offy_q <= offy_inc[OFF_W-1:0];
					end
				end
			end else begin
				x_q <= x_q + 1'b1;
				if (offx_inc == bs) begin
					offx_q <= '0;
					col_q  <= col_q + 1'b1;
				end else begin
					offx_q <= offx_inc[OFF_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_row_s1 <= (offy_q == '0);
			tile_end_s1  <= tile_end;
			fdone_s1     <= last_x && last_y;
			col_s1       <= col_q;
			row_s1       <= row_q;
			tw_s1        <= tw;
			th_s1        <= th;
			count_s1     <= area[CNT_W-1:0];
			px_s1        <= {pixel_in.pixel_red, pixel_in.pixel_green, pixel_in.pixel_blue};
		end
	end

	bap_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WIDTH)) u_sums (
		.clk   (clk),
		.we    (state_q == ST_ACC),
		.waddr (col_s1),
		.wdata (new_sums),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// On a tile's first row each pixel replaces the stored sums rather than adding to them.
	always_comb begin
		rd_sums = rd_data;
		for (int c = 0; c < 3; c++) begin
			new_sums[c] = first_row_s1 ? SUM_W'(px_s1[c]) : rd_sums[c] + SUM_W'(px_s1[c]);
		end
	end

	assign div_start = (state_q == ST_ACC) && tile_end_s1;

	bap_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sums   (new_sums),
		.count  (count_s1),
		.stat   (div_stat),
		.avg    (div_avg)
	);

	assign load_out = (state_q == ST_PUSH) && (!out_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (result_out.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_ACC;
				ST_ACC:  state_q <= tile_end_s1 ? ST_DIV : ST_IDLE;
				ST_DIV:  if (div_stat.done) state_q <= ST_PUSH;
				ST_PUSH: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q   <= div_avg;
			tcol_q  <= col_s1;
			trow_q  <= row_s1;
			tw_q    <= tw_s1;
			th_q    <= th_s1;
			fdone_q <= fdone_s1;
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.avg_blue    = avg_q[0];
	assign result_out.avg_green   = avg_q[1];
	assign result_out.avg_red     = avg_q[2];
	assign result_out.tile_column = tcol_q;
	assign result_out.tile_row    = trow_q;
	assign result_out.tile_width  = tw_q;
	assign result_out.tile_height = th_q;
	assign result_out.frame_done  = fdone_q;

endmodule

>>> rtl/bap_checker.sv
module bap_checker import bap_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] out_avg_blue,
	input logic [BS_W-1:0]  out_tile_width,
	input logic [BS_W-1:0]  out_tile_height
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_avg_blue) && $stable(out_tile_width))
		else $error("stalled result word changed");

	a_tile_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_tile_width != '0 && out_tile_height != '0 &&
			out_tile_width <= BS_W'(MAX_TILE) && out_tile_height <= BS_W'(MAX_TILE))
		else $error("tile size out of range");

	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel accepted while the previous one is still being added");

endmodule

bind block_average_pixelation bap_checker u_bap_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (pixel_in.valid),
	.in_ready        (pixel_in.ready),
	.out_valid       (result_out.valid),
	.out_ready       (result_out.ready),
	.out_avg_blue    (result_out.avg_blue),
	.out_tile_width  (result_out.tile_width),
	.out_tile_height (result_out.tile_height)
);
